// File: hdl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the ray/sphere side and distance unit
// Widths of the fixed point datapath, register indexes and pipeline sideband.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int POS_W   = 32;
    localparam int DIR_W   = 16;
    localparam int RAD_W   = 31;
    localparam int TOL_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 66;
    localparam int PROD_W  = 48;
    localparam int SUM_W   = 68;
    localparam int K30_W   = 50;
    localparam int K_W     = 36;
    localparam int KK_W    = 72;
    localparam int QUAD_W  = 72;
    localparam int ROOT_W  = 36;
    localparam int REM_W   = 38;
    localparam int DIST_W  = 38;
    localparam int FRAC_SHIFT = 14;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_TOL      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic                  outside;
        logic                  on_case;
        logic                  c_neg;
        logic                  k30_neg;
        logic                  quad_neg;
        logic signed [K_W-1:0] k;
    } side_t;

endpackage

// File: hdl/rss_front.sv
// ----------------------------------------------------------------------------
// rss_front: offset, products and quadratic terms
// Six register stages from the input transfer up to the radicand and side.
// ----------------------------------------------------------------------------
module rss_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic                                  in_fire,
    input  logic signed [rss_pkg::POS_W-1:0]      pos_x,
    input  logic signed [rss_pkg::POS_W-1:0]      pos_y,
    input  logic signed [rss_pkg::POS_W-1:0]      pos_z,
    input  logic signed [rss_pkg::DIR_W-1:0]      dir_x,
    input  logic signed [rss_pkg::DIR_W-1:0]      dir_y,
    input  logic signed [rss_pkg::DIR_W-1:0]      dir_z,
    input  logic                                  known_on_surface,
    input  logic signed [rss_pkg::POS_W-1:0]      cx,
    input  logic signed [rss_pkg::POS_W-1:0]      cy,
    input  logic signed [rss_pkg::POS_W-1:0]      cz,
    input  logic        [rss_pkg::RAD_W-1:0]      rad,
    input  logic        [rss_pkg::TOL_W-1:0]      tol,
    output logic                                  valid,
    output logic        [rss_pkg::QUAD_W-1:0]     quad,
    output rss_pkg::side_t                        side
);

    logic [5:0] v_reg;

    // stage 1: offsets
    logic signed [rss_pkg::DIFF_W-1:0] d1x_reg, d1y_reg, d1z_reg;
    logic signed [rss_pkg::DIR_W-1:0]  u1x_reg, u1y_reg, u1z_reg;
    logic                              os1_reg;
    // stage 2: products
    logic [rss_pkg::SQ_W-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic [2*rss_pkg::RAD_W-1:0]         r2_reg;
    logic signed [rss_pkg::PROD_W-1:0]   px_reg, py_reg, pz_reg;
    logic                                os2_reg;
    // stage 3: sums
    logic signed [rss_pkg::SUM_W-1:0]    c3_reg;
    logic signed [rss_pkg::K30_W-1:0]    k30_reg;
    logic                                os3_reg;
    // stage 4..6
    logic signed [rss_pkg::SUM_W-1:0]    c4_reg, c5_reg;
    logic [rss_pkg::K_W-1:0]             mk4_reg;
    logic [rss_pkg::KK_W-1:0]            kk5_reg;
    rss_pkg::side_t                      s4_reg, s5_reg, s6_reg;
    logic [rss_pkg::QUAD_W-1:0]          q6_reg;

    logic [rss_pkg::DIFF_W-1:0]          ax, ay, az;
    logic signed [rss_pkg::SUM_W-1:0]    sq_sum;
    logic signed [rss_pkg::K_W-1:0]      k_fl;
    logic signed [rss_pkg::SUM_W-1:0]    tol_s;
    logic                                c_gt, c_lt;
    rss_pkg::side_t                      s4_next;
    rss_pkg::side_t                      s6_next;
    logic signed [rss_pkg::QUAD_W:0]     quad_full;

    always_comb
    begin
        ax = d1x_reg[rss_pkg::DIFF_W-1] ? -d1x_reg : d1x_reg;
        ay = d1y_reg[rss_pkg::DIFF_W-1] ? -d1y_reg : d1y_reg;
        az = d1z_reg[rss_pkg::DIFF_W-1] ? -d1z_reg : d1z_reg;
        sq_sum = $signed({2'b00, sqx_reg}) + $signed({2'b00, sqy_reg})
               + $signed({2'b00, sqz_reg});
        // arithmetic shift floors toward minus infinity
        k_fl  = rss_pkg::K_W'(k30_reg >>> rss_pkg::FRAC_SHIFT);
        tol_s = $signed({{(rss_pkg::SUM_W-rss_pkg::TOL_W){1'b0}}, tol});
        c_gt  = c3_reg > tol_s;
        c_lt  = c3_reg < -tol_s;
        s4_next.outside  = c_gt ? 1'b1 : (c_lt ? 1'b0 : (k30_reg > 0));
        s4_next.on_case  = os3_reg || ((c3_reg < tol_s) && (c3_reg > -tol_s));
        s4_next.c_neg    = c3_reg[rss_pkg::SUM_W-1];
        s4_next.k30_neg  = k30_reg[rss_pkg::K30_W-1];
        s4_next.quad_neg = 1'b0;
        s4_next.k        = k_fl;
        quad_full = $signed({1'b0, kk5_reg})
                  - $signed({{(rss_pkg::QUAD_W+1-rss_pkg::SUM_W){c5_reg[rss_pkg::SUM_W-1]}},
                             c5_reg});
        s6_next          = s5_reg;
        s6_next.quad_neg = quad_full[rss_pkg::QUAD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[4:0], in_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1x_reg <= $signed({pos_x[rss_pkg::POS_W-1], pos_x}) - $signed({cx[rss_pkg::POS_W-1], cx});
            d1y_reg <= $signed({pos_y[rss_pkg::POS_W-1], pos_y}) - $signed({cy[rss_pkg::POS_W-1], cy});
            d1z_reg <= $signed({pos_z[rss_pkg::POS_W-1], pos_z}) - $signed({cz[rss_pkg::POS_W-1], cz});
            u1x_reg <= dir_x;
            u1y_reg <= dir_y;
            u1z_reg <= dir_z;
            os1_reg <= known_on_surface;

            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            sqz_reg <= az * az;
            r2_reg  <= rad * rad;
            px_reg  <= rss_pkg::PROD_W'(d1x_reg * u1x_reg);
            py_reg  <= rss_pkg::PROD_W'(d1y_reg * u1y_reg);
            pz_reg  <= rss_pkg::PROD_W'(d1z_reg * u1z_reg);
            os2_reg <= os1_reg;

            c3_reg  <= sq_sum - $signed({{(rss_pkg::SUM_W-2*rss_pkg::RAD_W){1'b0}}, r2_reg});
            k30_reg <= rss_pkg::K30_W'(px_reg) + rss_pkg::K30_W'(py_reg)
                     + rss_pkg::K30_W'(pz_reg);
            os3_reg <= os2_reg;

            c4_reg  <= c3_reg;
            mk4_reg <= k_fl[rss_pkg::K_W-1] ? rss_pkg::K_W'(-k_fl) : rss_pkg::K_W'(k_fl);
            s4_reg  <= s4_next;

            c5_reg  <= c4_reg;
            kk5_reg <= mk4_reg * mk4_reg;
            s5_reg  <= s4_reg;

            q6_reg  <= quad_full[rss_pkg::QUAD_W-1:0];
            s6_reg  <= s6_next;
        end
    end

    assign valid = v_reg[5];
    assign quad  = q6_reg;
    assign side  = s6_reg;

endmodule

// File: hdl/rss_root_step.sv
// ----------------------------------------------------------------------------
// rss_root_step: one registered digit of the integer square root
// Restoring root step: bring down two radicand bits, try root*4+1.
// ----------------------------------------------------------------------------
module rss_root_step
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               v_in,
    input  logic [rss_pkg::REM_W-1:0]          rem_in,
    input  logic [rss_pkg::ROOT_W-1:0]         root_in,
    input  logic [rss_pkg::QUAD_W-1:0]         q_in,
    input  rss_pkg::side_t                     side_in,
    output logic                               v_out,
    output logic [rss_pkg::REM_W-1:0]          rem_out,
    output logic [rss_pkg::ROOT_W-1:0]         root_out,
    output logic [rss_pkg::QUAD_W-1:0]         q_out,
    output rss_pkg::side_t                     side_out
);

    logic                              v_reg;
    logic [rss_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [rss_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [rss_pkg::QUAD_W-1:0]        q_reg;
    rss_pkg::side_t                    side_reg;
    logic [rss_pkg::REM_W+1:0]         rem_t, trial, diff;
    logic                              ge;

    always_comb
    begin
        rem_t     = {rem_in, q_in[rss_pkg::QUAD_W-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        ge        = rem_t >= trial;
        diff      = rem_t - trial;
        rem_next  = ge ? diff[rss_pkg::REM_W-1:0] : rem_t[rss_pkg::REM_W-1:0];
        root_next = {root_in[rss_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            q_reg    <= {q_in[rss_pkg::QUAD_W-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

// File: hdl/ray_sphere_side_and_distance.sv
// ----------------------------------------------------------------------------
// ray_sphere_side_and_distance: side test and ray distance for one sphere
// Top level: config registers, front pipeline, root pipeline, output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries a position (Q16.16), a direction
//   (Q2.14) and the on-surface flag. Output channel out_valid/out_ready
//   returns side, hit flag and travel distance (Q16.16, saturated).
//   Config: cfg_write with cfg_index/cfg_data writes one register per cycle;
//   write only while no transfer is in flight.
//   Depth: 6 front stages, 36 square root stages and 1 output register from
//   input transfer to out_valid. The 36-digit root, one digit per stage,
//   sets the depth.
//   Throughput: one transfer per cycle in both directions while out_ready stays high.
//   Reset clears all valid bits and loads the registers to center 0,
//   radius 0, tolerance 1.
//   When the receiver stalls, a two-entry output buffer takes the results in
//   flight; the whole pipeline then holds and in_ready drops until the
//   buffer drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_sphere_side_and_distance
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [2:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_x,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_y,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_z,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_x,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_y,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_z,
    input  logic                              known_on_surface,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              outside,
    output logic                              hit,
    output logic [31:0]                       travel_distance
);

    localparam int NSTEP = rss_pkg::ROOT_W;

    logic signed [rss_pkg::POS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [rss_pkg::RAD_W-1:0]        rad_reg;
    logic [rss_pkg::TOL_W-1:0]        tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= '0;
            tol_reg <= rss_pkg::TOL_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rss_pkg::REG_CENTER_X: cx_reg  <= cfg_data;
                rss_pkg::REG_CENTER_Y: cy_reg  <= cfg_data;
                rss_pkg::REG_CENTER_Z: cz_reg  <= cfg_data;
                rss_pkg::REG_RADIUS:   rad_reg <= cfg_data[rss_pkg::RAD_W-1:0];
                rss_pkg::REG_TOL:      tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic advance, skid_full_reg;
    assign advance  = !skid_full_reg;
    assign in_ready = advance;

    logic                        f_valid;
    logic [rss_pkg::QUAD_W-1:0]  f_quad;
    rss_pkg::side_t              f_side;

    rss_front u_front
    (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_fire(in_valid && in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .known_on_surface(known_on_surface),
        .cx(cx_reg), .cy(cy_reg), .cz(cz_reg), .rad(rad_reg), .tol(tol_reg),
        .valid(f_valid), .quad(f_quad), .side(f_side)
    );

    logic                        sv   [NSTEP+1];
    logic [rss_pkg::REM_W-1:0]   srem [NSTEP+1];
    logic [rss_pkg::ROOT_W-1:0]  sroot[NSTEP+1];
    logic [rss_pkg::QUAD_W-1:0]  sq   [NSTEP+1];
    rss_pkg::side_t              sside[NSTEP+1];

    assign sv[0]    = f_valid;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sq[0]    = f_quad;
    assign sside[0] = f_side;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_root
        rss_root_step u_step
        (
            .clk(clk), .rst_n(rst_n), .advance(advance),
            .v_in(sv[i]), .rem_in(srem[i]), .root_in(sroot[i]), .q_in(sq[i]),
            .side_in(sside[i]),
            .v_out(sv[i+1]), .rem_out(srem[i+1]), .root_out(sroot[i+1]),
            .q_out(sq[i+1]), .side_out(sside[i+1])
        );
    end

    // final selection of root and distance clamp
    rss_pkg::side_t                   fs;
    logic signed [rss_pkg::DIST_W-1:0] neg_k, far_d, near_d, sel_d;
    logic                             r_hit;
    logic [31:0]                      r_td;
    logic                             r_out;

    always_comb
    begin
        fs     = sside[NSTEP];
        neg_k  = -$signed({{(rss_pkg::DIST_W-rss_pkg::K_W){fs.k[rss_pkg::K_W-1]}}, fs.k});
        far_d  = neg_k + $signed({2'b00, sroot[NSTEP]});
        near_d = neg_k - $signed({2'b00, sroot[NSTEP]});
        r_out  = fs.outside;
        priority if (fs.quad_neg)
        begin
            r_hit = 1'b0;
            sel_d = far_d;
        end
        else if (fs.on_case)
        begin
            r_hit = fs.k30_neg;
            sel_d = far_d;
        end
        else if (fs.c_neg)
        begin
            r_hit = 1'b1;
            sel_d = far_d;
        end
        else
        begin
            r_hit = !near_d[rss_pkg::DIST_W-1];
            sel_d = near_d;
        end
        priority if (!r_hit || sel_d[rss_pkg::DIST_W-1])
            r_td = '0;
        else if (sel_d[rss_pkg::DIST_W-2:32] != '0)
            r_td = '1;
        else
            r_td = sel_d[31:0];
    end

    // output register plus skid entry
    logic        out_v_reg;
    logic        o_out_reg, o_hit_reg, s_out_reg, s_hit_reg;
    logic [31:0] o_td_reg, s_td_reg;
    logic        incoming;

    assign incoming = advance && sv[NSTEP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg     <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_v_reg && !out_ready)
        begin
            if (incoming)
                skid_full_reg <= 1'b1;
        end
        else
        begin
            out_v_reg     <= skid_full_reg || incoming;
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !out_ready)
        begin
            if (incoming)
            begin
                s_out_reg <= r_out;
                s_hit_reg <= r_hit;
                s_td_reg  <= r_td;
            end
        end
        else if (skid_full_reg)
        begin
            o_out_reg <= s_out_reg;
            o_hit_reg <= s_hit_reg;
            o_td_reg  <= s_td_reg;
        end
        else
        begin
            o_out_reg <= r_out;
            o_hit_reg <= r_hit;
            o_td_reg  <= r_td;
        end
    end

    assign out_valid       = out_v_reg;
    assign outside         = o_out_reg;
    assign hit             = o_hit_reg;
    assign travel_distance = o_td_reg;

endmodule

// File: hdl/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_port_checks: port-level checks for the ray/sphere unit
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module rss_port_checks
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        hit,
    input  logic [31:0] travel_distance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(travel_distance) && $stable(hit))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> travel_distance == 32'd0)
        else $error("distance nonzero on miss");

    a_ready_buf: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with empty output");

endmodule

bind ray_sphere_side_and_distance rss_port_checks u_rss_checker
(
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .hit(hit), .travel_distance(travel_distance)
);

// File: dv/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker: result predictor and comparator for the ray/sphere unit
// Tracks register writes, predicts side, hit and distance for every input
// transfer and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rss_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [2:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_x,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_y,
    input  logic signed [rss_pkg::POS_W-1:0]  pos_z,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_x,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_y,
    input  logic signed [rss_pkg::DIR_W-1:0]  dir_z,
    input  logic                              known_on_surface,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              outside,
    input  logic                              hit,
    input  logic [31:0]                       travel_distance,
    output int                                fails,
    output int                                pending,
    output int                                hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        outside;
        logic        hit;
        logic [31:0] td;
    } answer_t;

    logic signed [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0]        rad;
    logic [31:0]        tol;
    answer_t            answers[$];

    assign pending = answers.size();

    function automatic answer_t sphere_answer(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz, input logic signed [15:0] ux,
        input logic signed [15:0] uy, input logic signed [15:0] uz,
        input logic on_surf);
        logic signed [95:0] dx, dy, dz, c, abs_c, rv, tv, k30, k, quad, root, cand, span;
        answer_t a;
        dx = $signed(px) - $signed(ctr_x);
        dy = $signed(py) - $signed(ctr_y);
        dz = $signed(pz) - $signed(ctr_z);
        rv = $signed({65'd0, rad});
        tv = $signed({64'd0, tol});
        c = dx * dx + dy * dy + dz * dz - rv * rv;
        abs_c = (c < 0) ? -c : c;
        k30 = dx * ux + dy * uy + dz * uz;
        k = k30 >>> rss_pkg::FRAC_SHIFT;
        if (c > tv)
            a.outside = 1'b1;
        else if (c < -tv)
            a.outside = 1'b0;
        else
            a.outside = (k30 > 0);
        quad = k * k - c;
        a.hit = 1'b0;
        span = 0;
        if (quad >= 0) begin
            root = 0;
            for (int b = 35; b >= 0; b--) begin
                cand = root | (96'sd1 <<< b);
                if (cand * cand <= quad)
                    root = cand;
            end
            if (on_surf || abs_c < tv) begin
                if (k30 < 0)
                begin
                    a.hit = 1'b1;
                    span = -k + root;
                end
            end else if (c < 0) begin
                a.hit = 1'b1;
                span = -k + root;
            end else begin
                span = -k - root;
                a.hit = (span >= 0);
            end
        end
        if (!a.hit || span < 0)
            a.td = 32'd0;
        else if (span > 96'sh0FFFF_FFFF)
            a.td = 32'hFFFF_FFFF;
        else
            a.td = span[31:0];
        return a;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        hits_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x <= '0;
            ctr_y <= '0;
            ctr_z <= '0;
            rad   <= '0;
            tol   <= 32'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rss_pkg::REG_CENTER_X: ctr_x <= cfg_data;
                rss_pkg::REG_CENTER_Y: ctr_y <= cfg_data;
                rss_pkg::REG_CENTER_Z: ctr_z <= cfg_data;
                rss_pkg::REG_RADIUS:   rad   <= cfg_data[30:0];
                rss_pkg::REG_TOL:      tol   <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && in_valid && in_ready)
            answers.push_back(sphere_answer(pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                                            known_on_surface));
        if (rst_n && out_valid && out_ready)
        begin
            if (answers.size() == 0)
                report("unexpected transfer", {30'd0, outside, hit}, 32'd0);
            else
            begin
                want = answers.pop_front();
                if (outside !== want.outside)
                    report("outside", 32'(outside), 32'(want.outside));
                if (hit !== want.hit)
                    report("hit", 32'(hit), 32'(want.hit));
                if (travel_distance !== want.td)
                    report("travel_distance", travel_distance, want.td);
                if (want.hit)
                    hits_seen++;
            end
        end
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for ray_sphere_side_and_distance
// Drives directed and random particle queries under several sphere settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 60;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic               known_on_surface;
    logic               out_valid;
    logic               out_ready;
    logic               outside;
    logic               hit;
    logic [31:0]        travel_distance;
    int                 fails, pending, hits_seen;
    int                 idle_cycles;
    int                 sent;
    logic               calm;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        rr;

    ray_sphere_side_and_distance u_top (.*);

    rss_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: stall about 21 percent of the time, never in the calm window
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending);
            $display("FAIL ray_sphere_side_and_distance");
            $finish;
        end
    end

    task automatic write_reg(input rss_pkg::reg_index_t idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let the last transfer reach the checker before counting
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_sphere(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic [30:0] r,
                              input logic [31:0] t);
        drain();
        write_reg(rss_pkg::REG_CENTER_X, x);
        write_reg(rss_pkg::REG_CENTER_Y, y);
        write_reg(rss_pkg::REG_CENTER_Z, z);
        write_reg(rss_pkg::REG_RADIUS, {1'b0, r});
        write_reg(rss_pkg::REG_TOL, t);
        cx = x;
        cy = y;
        cz = z;
        rr = r;
    endtask

    task automatic send(input logic signed [31:0] px, input logic signed [31:0] py,
                        input logic signed [31:0] pz, input logic signed [15:0] ux,
                        input logic signed [15:0] uy, input logic signed [15:0] uz,
                        input logic ks);
        if (!calm && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        dir_x <= ux;
        dir_y <= uy;
        dir_z <= uz;
        known_on_surface <= ks;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd11585;
            3: return -16'sd11585;
            4: return 16'sd0;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    // a point on or near the sphere along a random axis, or pure noise
    task automatic send_random();
        logic signed [63:0] off [3];
        logic signed [63:0] scale;
        int axis;
        if ($urandom_range(0, 9) < 2)
        begin
            send($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom));
            return;
        end
        axis = $urandom_range(0, 2);
        foreach (off[i])
            off[i] = $signed(64'($urandom_range(0, 2047))) - 64'sd1024;
        case ($urandom_range(0, 3))
            0: scale = 64'sd1024;
            1: scale = 64'($urandom_range(0, 2048));
            2: scale = 64'($urandom_range(0, 8192));
            default: scale = 64'($urandom_range(0, 1024));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            foreach (off[i])
                off[i] = 0;
            scale = 64'sd1024;
        end
        off[axis] = off[axis] + (($signed({33'd0, rr}) * scale) >>> 10)
                    * ($urandom_range(0, 1) ? 1 : -1);
        send(32'(cx + off[0]), 32'(cy + off[1]), 32'(cz + off[2]),
             pick_dir(), pick_dir(), pick_dir(), ($urandom_range(0, 4) == 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        known_on_surface = 1'b0;
        out_ready = 1'b0;
        idle_cycles = 0;
        sent = 0;
        calm = 1'b0;
        cx = 0;
        cy = 0;
        cz = 0;
        rr = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero radius, tolerance one
        send(0, 0, 0, 16384, 0, 0, 0);
        send(32'h0001_0000, 0, 0, -16384, 0, 0, 0);

        set_sphere(0, 0, 0, 31'h0001_0000, 32'd1);
        send(32'h0001_0000, 0, 0, 16384, 0, 0, 0);        // on surface, leaving
        send(32'h0001_0000, 0, 0, -16384, 0, 0, 0);       // on surface, entering
        send(32'h0001_0000, 0, 0, 0, 16384, 0, 0);        // on surface, tangent
        send(0, 0, 0, 0, 0, 16384, 0);                    // center, inside
        send(32'h0000_8000, 32'h0000_4000, 0, 11585, 11585, 0, 0);
        send(32'h0003_0000, 0, 0, -16384, 0, 0, 0);       // outside, hits
        send(32'h0003_0000, 0, 0, 16384, 0, 0, 0);        // outside, away
        send(32'h0003_0000, 32'h0003_0000, 0, -16384, 0, 0, 0); // outside, misses
        send(32'h0000_4000, 0, 0, 16384, 0, 0, 1);        // caller claims on surface
        send(32'h0003_0000, 0, 0, -16384, 0, 0, 1);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 1);
        send(32'h8000_0000, 0, 0, 16384, 0, 0, 0);
        send(32'h0001_0001, 0, 0, 16384, 0, 0, 0);        // just off surface
        send(32'h0000_FFFF, 0, 0, 16384, 0, 0, 0);

        // extreme sphere: largest radius, widest band, far center
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16384, 0, 0, 0);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 9459, 9459, 9459, 0);
        send(0, 0, 0, -16384, 16384, -16384, 0);
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16384, -16384, 16384, 1);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_sphere(0, 0, 0, 31'h0001_0000, 32'd1);
                1: set_sphere($urandom, $urandom, $urandom,
                              31'($urandom_range(0, 32'h0100_0000)), 32'd0);
                2: set_sphere($urandom, $urandom, $urandom, 31'($urandom), $urandom);
                3: set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
                4: set_sphere($urandom, $urandom, $urandom, 31'd0, 32'd1);
                default: set_sphere($urandom, $urandom, $urandom,
                                    31'($urandom_range(1, 32'h0010_0000)),
                                    $urandom_range(0, 64));
            endcase
            for (int n = 0; n < 170; n++)
            begin
                calm = (phase == 2 && n >= 20 && n < 140);
                send_random();
            end
            calm = 1'b0;
        end

        drain();
        $display("covered %0d queries over nine sphere settings, %0d of them hits",
                 sent, hits_seen);
        if (fails == 0)
            $display("PASS ray_sphere_side_and_distance");
        else
            $display("FAIL ray_sphere_side_and_distance");
        $finish;
    end

endmodule
